[hw/rtl/dds_pkg.sv]
// Shared types and constants of the differential-drive speed stepper.
package dds_pkg;

  // Command kinds carried in req_type
  typedef enum logic [2:0] {
    REQ_STOP    = 3'd0,
    REQ_FORWARD = 3'd1,
    REQ_BACK    = 3'd2,
    REQ_RIGHT   = 3'd3,
    REQ_LEFT    = 3'd4
  } dds_req_e;

  // Register word indexes on the configuration port
  typedef enum logic [2:0] {
    REG_FORWARD_LIMIT = 3'd0,
    REG_BACKWARD_LIMIT = 3'd1,
    REG_LINEAR_INC    = 3'd2,
    REG_TURN_INC      = 3'd3,
    REG_MAX_WHEEL_DIFF = 3'd4
  } dds_reg_e;

  // Serial command codes reported in the result
  localparam logic [3:0] CODE_NONE     = 4'd0;
  localparam logic [3:0] CODE_STOP     = 4'd1;
  localparam logic [3:0] CODE_FORWARD1 = 4'd2;
  localparam logic [3:0] CODE_BACK1    = 4'd5;
  localparam logic [3:0] CODE_RIGHT1   = 4'd8;
  localparam logic [3:0] CODE_LEFT1    = 4'd11;

  // Valid step multiples
  localparam logic [3:0] MULT_X1  = 4'd1;
  localparam logic [3:0] MULT_X5  = 4'd5;
  localparam logic [3:0] MULT_X10 = 4'd10;

  localparam int unsigned InDataBits  = 8;
  localparam int unsigned OutDataBits = 56;

  // Configuration registers
  typedef struct packed {
    logic [10:0]        forward_limit;
    logic signed [11:0] backward_limit;
    logic [6:0]         linear_inc;
    logic [6:0]         turn_inc;
    logic [11:0]        max_wheel_difference;
  } dds_cfg_t;

  // Result item, laid out as on the output tdata (status in bit 0)
  typedef struct packed {
    logic [1:0]         pad;
    logic signed [12:0] rotation_speed;
    logic signed [11:0] mean_speed;
    logic signed [11:0] left_speed;
    logic signed [11:0] right_speed;
    logic [3:0]         command_code;
    logic               status;
  } dds_result_t;

endpackage

[hw/rtl/dds_step.sv]
// Combinational command evaluation: new wheel speeds, limit checks, result fields.
module dds_step import dds_pkg::*; #(
  parameter int unsigned SPEED_BITS = 12
) (
  input  logic [2:0]              req_type_i,
  input  logic [3:0]              step_multiple_i,
  input  logic                    link_ok_i,
  input  dds_cfg_t                cfg_i,
  input  logic [SPEED_BITS-1:0]   right_wheel_i,
  input  logic [SPEED_BITS-1:0]   left_wheel_i,
  output logic [SPEED_BITS-1:0]   right_wheel_o,
  output logic [SPEED_BITS-1:0]   left_wheel_o,
  output logic                    ok_o,
  output dds_result_t             result_o
);

  // Working width: holds any wheel plus a step and their difference without wrap
  localparam int unsigned CW = ((SPEED_BITS > 13) ? SPEED_BITS : 13) + 3;

  logic signed [CW-1:0] r_cur, l_cur, r_new, l_new, delta, diff, diff_abs;
  logic signed [CW-1:0] fwd_lim, bwd_lim, max_diff;
  logic signed [CW-1:0] r_out, l_out, sum, mean, rot;
  logic [CW-1:0]        step_sel;
  logic                 mult_ok, lim_ok, chk_diff, fits_r, fits_l, ok;
  logic [1:0]           mult_idx;
  logic [3:0]           code;

  // Widen state and limits
  assign r_cur    = {{(CW-SPEED_BITS){right_wheel_i[SPEED_BITS-1]}}, right_wheel_i};
  assign l_cur    = {{(CW-SPEED_BITS){left_wheel_i[SPEED_BITS-1]}}, left_wheel_i};
  assign fwd_lim  = signed'({{(CW-11){1'b0}}, cfg_i.forward_limit});
  assign bwd_lim  = {{(CW-12){cfg_i.backward_limit[11]}}, cfg_i.backward_limit};
  assign max_diff = signed'({{(CW-12){1'b0}}, cfg_i.max_wheel_difference});

  // Multiple decode
  always_comb begin
    mult_ok  = 1'b1;
    mult_idx = 2'd0;
    unique case (step_multiple_i)
      MULT_X1:  mult_idx = 2'd0;
      MULT_X5:  mult_idx = 2'd1;
      MULT_X10: mult_idx = 2'd2;
      default:  mult_ok  = 1'b0;
    endcase
  end

  // Step size: multiple times the selected step (at most 10 x 127 for a valid multiple)
  assign step_sel = (req_type_i == REQ_FORWARD || req_type_i == REQ_BACK) ?
                    {{(CW-7){1'b0}}, cfg_i.linear_inc} :
                    {{(CW-7){1'b0}}, cfg_i.turn_inc};
  assign delta = signed'(CW'({{(CW-4){1'b0}}, step_multiple_i} * step_sel));

  // Candidate speeds and limit tests
  always_comb begin
    r_new    = r_cur;
    l_new    = l_cur;
    lim_ok   = 1'b0;
    chk_diff = 1'b0;
    code     = CODE_NONE;
    unique case (req_type_i)
      REQ_STOP: begin
        r_new  = '0;
        l_new  = '0;
        lim_ok = 1'b1;
        code   = CODE_STOP;
      end
      REQ_FORWARD: begin
        r_new  = r_cur + delta;
        l_new  = l_cur + delta;
        lim_ok = mult_ok && (r_new <= fwd_lim) && (l_new <= fwd_lim);
        code   = CODE_FORWARD1 + {2'b00, mult_idx};
      end
      REQ_BACK: begin
        r_new  = r_cur - delta;
        l_new  = l_cur - delta;
        lim_ok = mult_ok && (r_new >= bwd_lim) && (l_new >= bwd_lim);
        code   = CODE_BACK1 + {2'b00, mult_idx};
      end
      REQ_RIGHT: begin
        r_new    = r_cur - delta;
        l_new    = l_cur + delta;
        lim_ok   = mult_ok && (r_new >= bwd_lim) && (l_new <= fwd_lim);
        chk_diff = 1'b1;
        code     = CODE_RIGHT1 + {2'b00, mult_idx};
      end
      REQ_LEFT: begin
        r_new    = r_cur + delta;
        l_new    = l_cur - delta;
        lim_ok   = mult_ok && (r_new <= fwd_lim) && (l_new >= bwd_lim);
        chk_diff = 1'b1;
        code     = CODE_LEFT1 + {2'b00, mult_idx};
      end
      default: lim_ok = 1'b0;
    endcase
  end

  // Turn difference, magnitude
  assign diff     = r_new - l_new;
  assign diff_abs = diff[CW-1] ? -diff : diff;

  // Width guard for the stored speeds
  assign fits_r = ({{(CW-SPEED_BITS){r_new[SPEED_BITS-1]}}, r_new[SPEED_BITS-1:0]} == r_new);
  assign fits_l = ({{(CW-SPEED_BITS){l_new[SPEED_BITS-1]}}, l_new[SPEED_BITS-1:0]} == l_new);

  assign ok = link_ok_i && lim_ok && (!chk_diff || (diff_abs <= max_diff)) &&
              fits_r && fits_l;

  // Committed speeds
  assign r_out = ok ? r_new : r_cur;
  assign l_out = ok ? l_new : l_cur;
  assign right_wheel_o = r_out[SPEED_BITS-1:0];
  assign left_wheel_o  = l_out[SPEED_BITS-1:0];
  assign ok_o = ok;

  // Mean rounded toward zero
  assign sum  = r_out + l_out;
  assign mean = (sum + {{(CW-1){1'b0}}, sum[CW-1]}) >>> 1;

  // Rotation speed
  assign rot = r_out - l_out;

  always_comb begin
    result_o                = '0;
    result_o.status         = !ok;
    result_o.command_code   = ok ? code : CODE_NONE;
    result_o.right_speed    = r_out[11:0];
    result_o.left_speed     = l_out[11:0];
    result_o.mean_speed     = mean[11:0];
    result_o.rotation_speed = rot[12:0];
  end

endmodule

[hw/rtl/differential_drive_speed_stepper_top.sv]
// Differential-drive speed stepper: command stream in, wheel speed results out.
//
// Usage:
//   Slave stream (s_axis_*): one command per request, 8-bit tdata holding
//   req_type, step_multiple and link_ok. Master stream (m_axis_*): exactly
//   one result per command: status, command code and the four speed fields.
//   APB port: five readable 32-bit registers at byte addresses 0x00..0x10
//   (forward/backward limit, speed/rotation step, max wheel difference); the
//   user writes them only while no command is in flight (not enforced).
// Timing:
//   A command is evaluated in the cycle it is accepted; its result appears
//   on the master side the next cycle. One command per cycle is sustained
//   while m_axis_tready stays high; the single output register sets that figure.
// Reset:
//   Both wheel speeds go to zero, registers take their default values and
//   the output register empties.
// Stall:
//   While a result waits on a low m_axis_tready the output register holds
//   it and s_axis_tready drops; it stays high when the result leaves in
//   the same cycle.
module differential_drive_speed_stepper_top import dds_pkg::*; #(
  parameter int unsigned SPEED_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Command stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [InDataBits-1:0]  s_axis_tdata,  // req_type[2:0], step_multiple[6:3], link_ok[7]
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OutDataBits-1:0] m_axis_tdata,  // status[0], command_code[4:1],
                                                // right_speed[16:5], left_speed[28:17],
                                                // mean_speed[40:29], rotation_speed[53:41]
  // Configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  dds_cfg_t              cfg_q;
  logic [SPEED_BITS-1:0] right_wheel_q, left_wheel_q;
  logic [SPEED_BITS-1:0] right_wheel_d, left_wheel_d;
  dds_result_t           out_q, result;
  logic                  out_valid_q;
  logic                  s_fire, step_ok, cfg_wr;
  logic [2:0]            reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.forward_limit        <= 11'd100;
      cfg_q.backward_limit       <= -12'sd100;
      cfg_q.linear_inc           <= 7'd1;
      cfg_q.turn_inc             <= 7'd1;
      cfg_q.max_wheel_difference <= 12'd100;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FORWARD_LIMIT:  cfg_q.forward_limit        <= pwdata[10:0];
        REG_BACKWARD_LIMIT: cfg_q.backward_limit       <= pwdata[11:0];
        REG_LINEAR_INC:     cfg_q.linear_inc           <= pwdata[6:0];
        REG_TURN_INC:       cfg_q.turn_inc             <= pwdata[6:0];
        REG_MAX_WHEEL_DIFF: cfg_q.max_wheel_difference <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      REG_FORWARD_LIMIT:  prdata = {21'd0, cfg_q.forward_limit};
      REG_BACKWARD_LIMIT: prdata = {{20{cfg_q.backward_limit[11]}}, cfg_q.backward_limit};
      REG_LINEAR_INC:     prdata = {25'd0, cfg_q.linear_inc};
      REG_TURN_INC:       prdata = {25'd0, cfg_q.turn_inc};
      REG_MAX_WHEEL_DIFF: prdata = {20'd0, cfg_q.max_wheel_difference};
      default:            prdata = '0;
    endcase
  end

  // Command evaluation
  dds_step #(
    .SPEED_BITS(SPEED_BITS)
  ) u_step (
    .req_type_i      (s_axis_tdata[2:0]),
    .step_multiple_i (s_axis_tdata[6:3]),
    .link_ok_i       (s_axis_tdata[7]),
    .cfg_i           (cfg_q),
    .right_wheel_i   (right_wheel_q),
    .left_wheel_i    (left_wheel_q),
    .right_wheel_o   (right_wheel_d),
    .left_wheel_o    (left_wheel_d),
    .ok_o            (step_ok),
    .result_o        (result)
  );

  // Accept while the output register is empty or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Wheel state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_wheel_q <= '0;
      left_wheel_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (s_fire) begin
        right_wheel_q <= right_wheel_d;
        left_wheel_q  <= left_wheel_d;
      end
      if (s_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // A refused command leaves both wheel speeds untouched
  a_refused_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !step_ok |=> $stable(right_wheel_q) && $stable(left_wheel_q))
    else $error("refused command changed wheel speeds");

  // Every accepted command produces a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> m_axis_tvalid)
    else $error("accepted command gave no result");

  // Status and command code agree: accepted means a nonzero code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.status == (out_q.command_code == CODE_NONE)))
    else $error("status and command code disagree");

endmodule
